>>> rtl/core/b32m_pkg.sv
// package: shared types, constants and checksum function of the address encoder
`timescale 1ns / 1ps

package b32m_pkg;

  // key length and derived widths
  localparam int KEY_BYTES = 32;
  localparam int IDX_W     = 6;

  // command queue sizing
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // checksum length in characters, and the step index of its last character
  localparam int CHK_LEN = 6;
  localparam logic [2:0] CHK_LAST = 3'(CHK_LEN - 1);

  // polymod constants
  localparam logic [29:0] POLY_GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };
  localparam logic [29:0] POLY_LOW_MASK = 30'h1ffffff;
  localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;

  // data charset, ascii codes of "qpzry9x8gf2tvdw0s3jn54khce6mua7l"
  localparam logic [6:0] CHARSET [32] = '{
    7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
    7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
    7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
    7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
  };

  // fixed prefix "bc1p"
  localparam logic [6:0] PREFIX_CHARS [4] = '{7'h62, 7'h63, 7'h31, 7'h70};

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_PREFIX,
    CMD_SYM,
    CMD_CHECK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [4:0] value;
  } cmd_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } res_t;

  // front sequencer states
  typedef enum logic [2:0] {
    F_IDLE,
    F_PREFIX,
    F_SYM,
    F_PAD,
    F_CHECK
  } f_state_e;

  // back sequencer states
  typedef enum logic [1:0] {
    B_RUN,
    B_FOLD,
    B_EMIT
  } b_state_e;

  // one polymod step: shift in a 5-bit value and reduce
  function automatic logic [29:0] poly_fold(input logic [29:0] chk, input logic [4:0] v);
    logic [29:0] r;
    logic [4:0]  top;
    top = chk[29:25];
    r   = ((chk & POLY_LOW_MASK) << 5) | {25'd0, v};
    for (int i = 0; i < 5; i++) begin
      if (top[i]) begin
        r = r ^ POLY_GEN[i];
      end
    end
    return r;
  endfunction

  // polymod after the prefix expansion 3,3,0,2,3 and witness version 1
  localparam logic [29:0] POLY_INIT =
    poly_fold(poly_fold(poly_fold(poly_fold(poly_fold(poly_fold(
      30'd1, 5'd3), 5'd3), 5'd0), 5'd2), 5'd3), 5'd1);

endpackage

>>> rtl/core/b32m_front.sv
// front end: takes key bytes, regroups bits and issues prefix, symbol and checksum commands
`timescale 1ns / 1ps

module b32m_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          key_byte_i,
  output logic                cmd_push_o,
  output b32m_pkg::cmd_t      cmd_o,
  input  logic                cmd_full_i
);

  b32m_pkg::f_state_e            state_q, state_d, state_n;
  logic [11:0]                   buf_q, buf_d, buf_n;
  logic [3:0]                    cnt_q, cnt_d, cnt_n;
  logic [b32m_pkg::IDX_W-1:0]    idx_q, idx_d, idx_n;
  logic                          last_q, last_d;
  logic [1:0]                    pidx_q, pidx_d;
  logic [3:0]                    sym_shift;
  logic [2:0]                    pad_shift;
  logic [4:0]                    sym_val;
  logic [4:0]                    pad_val;
  logic                          accept;

  // symbol extraction from the bit buffer
  assign sym_shift = cnt_q - 4'd5;
  assign sym_val   = 5'(buf_q >> sym_shift);
  assign pad_shift = 3'(4'd5 - cnt_q);
  assign pad_val   = 5'(buf_q << pad_shift);

  // one command per cycle from the current byte while the command queue has room
  always_comb begin
    state_n    = state_q;
    buf_n      = buf_q;
    cnt_n      = cnt_q;
    idx_n      = idx_q;
    pidx_d     = pidx_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: b32m_pkg::CMD_SYM, value: 5'd0};
    unique case (state_q)
      b32m_pkg::F_IDLE: begin
      end
      b32m_pkg::F_PREFIX: begin
        cmd_o      = '{kind: b32m_pkg::CMD_PREFIX, value: {3'd0, pidx_q}};
        cmd_push_o = !cmd_full_i;
        if (!cmd_full_i) begin
          pidx_d = pidx_q + 2'd1;
          if (pidx_q == 2'd3) begin
            state_n = b32m_pkg::F_SYM;
          end
        end
      end
      b32m_pkg::F_SYM: begin
        cmd_o      = '{kind: b32m_pkg::CMD_SYM, value: sym_val};
        cmd_push_o = !cmd_full_i;
        if (!cmd_full_i) begin
          cnt_n = sym_shift;
          if (sym_shift < 4'd5) begin
            if (last_q) begin
              state_n = (sym_shift != 4'd0) ? b32m_pkg::F_PAD : b32m_pkg::F_CHECK;
            end else begin
              state_n = b32m_pkg::F_IDLE;
            end
          end
        end
      end
      b32m_pkg::F_PAD: begin
        cmd_o      = '{kind: b32m_pkg::CMD_SYM, value: pad_val};
        cmd_push_o = !cmd_full_i;
        if (!cmd_full_i) begin
          state_n = b32m_pkg::F_CHECK;
        end
      end
      b32m_pkg::F_CHECK: begin
        cmd_o      = '{kind: b32m_pkg::CMD_CHECK, value: 5'd0};
        cmd_push_o = !cmd_full_i;
        if (!cmd_full_i) begin
          buf_n   = 12'd0;
          cnt_n   = 4'd0;
          idx_n   = '0;
          state_n = b32m_pkg::F_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // a new byte is taken in the cycle the previous one finishes
  assign full   = (state_n != b32m_pkg::F_IDLE);
  assign accept = push && !full;

  // load the accepted byte on top of what is left
  always_comb begin
    state_d = state_n;
    buf_d   = buf_n;
    cnt_d   = cnt_n;
    idx_d   = idx_n;
    last_d  = last_q;
    if (accept) begin
      buf_d   = {buf_n[3:0], key_byte_i};
      cnt_d   = cnt_n + 4'd8;
      idx_d   = idx_n + 1'b1;
      last_d  = ({1'b0, idx_n} + 7'd1) == 7'(b32m_pkg::KEY_BYTES);
      state_d = (idx_n == '0) ? b32m_pkg::F_PREFIX : b32m_pkg::F_SYM;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b32m_pkg::F_IDLE;
      buf_q   <= 12'd0;
      cnt_q   <= 4'd0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      pidx_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      pidx_q  <= accept ? 2'd0 : pidx_d;
    end
  end

endmodule

>>> rtl/core/b32m_cmd_q.sv
// command queue between front end and back end
`timescale 1ns / 1ps

module b32m_cmd_q (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b32m_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output b32m_pkg::cmd_t      cmd_o,
  output logic                empty_o
);

  b32m_pkg::cmd_t                 mem_q [b32m_pkg::CMDQ_DEPTH];
  logic [b32m_pkg::CMDQ_AW-1:0]   wr_q, rd_q;
  logic [b32m_pkg::CMDQ_CW-1:0]   cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == b32m_pkg::CMDQ_CW'(b32m_pkg::CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == b32m_pkg::CMDQ_AW'(b32m_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == b32m_pkg::CMDQ_AW'(b32m_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/b32m_back.sv
// back end: checksum folding, character mapping and result queue
`timescale 1ns / 1ps

module b32m_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b32m_pkg::cmd_t      cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  input  logic                pop,
  output logic                empty,
  output logic [6:0]          address_char_o,
  output logic                last_char_o
);

  b32m_pkg::b_state_e  state_q, state_d;
  logic [29:0]         poly_q, poly_d;
  logic [29:0]         fold_zero;
  logic [2:0]          step_q, step_d;
  b32m_pkg::res_t      res_mem_q [2];
  logic                res_wr_q, res_rd_q;
  logic [1:0]          res_cnt_q;
  logic                res_push;
  b32m_pkg::res_t      res_in;
  logic                res_pop;
  logic                space;

  assign res_pop   = pop && !empty;
  assign space     = (res_cnt_q != 2'd2) || res_pop;
  assign fold_zero = b32m_pkg::poly_fold(poly_q, 5'd0);

  // command execution
  always_comb begin
    state_d   = state_q;
    poly_d    = poly_q;
    step_d    = step_q;
    cmd_pop_o = 1'b0;
    res_push  = 1'b0;
    res_in    = '{ch: 7'd0, last: 1'b0};
    unique case (state_q)
      b32m_pkg::B_RUN: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            b32m_pkg::CMD_PREFIX: begin
              if (space) begin
                res_push  = 1'b1;
                res_in    = '{ch: b32m_pkg::PREFIX_CHARS[cmd_i.value[1:0]], last: 1'b0};
                cmd_pop_o = 1'b1;
              end
            end
            b32m_pkg::CMD_SYM: begin
              if (space) begin
                res_push  = 1'b1;
                res_in    = '{ch: b32m_pkg::CHARSET[cmd_i.value], last: 1'b0};
                poly_d    = b32m_pkg::poly_fold(poly_q, cmd_i.value);
                cmd_pop_o = 1'b1;
              end
            end
            b32m_pkg::CMD_CHECK: begin
              cmd_pop_o = 1'b1;
              step_d    = 3'd0;
              state_d   = b32m_pkg::B_FOLD;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      b32m_pkg::B_FOLD: begin
        // six zero folds, then the bech32m constant
        step_d = step_q + 3'd1;
        poly_d = fold_zero;
        if (step_q == b32m_pkg::CHK_LAST) begin
          poly_d  = fold_zero ^ b32m_pkg::BECH32M_CONST;
          step_d  = 3'd0;
          state_d = b32m_pkg::B_EMIT;
        end
      end
      b32m_pkg::B_EMIT: begin
        // checksum characters, most significant group first
        if (space) begin
          res_push = 1'b1;
          res_in   = '{ch: b32m_pkg::CHARSET[poly_q[29:25]],
                       last: (step_q == b32m_pkg::CHK_LAST)};
          poly_d   = poly_q << 5;
          step_d   = step_q + 3'd1;
          if (step_q == b32m_pkg::CHK_LAST) begin
            poly_d  = b32m_pkg::POLY_INIT;
            step_d  = 3'd0;
            state_d = b32m_pkg::B_RUN;
          end
        end
      end
      default: begin
        state_d = b32m_pkg::B_RUN;
      end
    endcase
  end

  // sequencer and checksum registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b32m_pkg::B_RUN;
      poly_q  <= b32m_pkg::POLY_INIT;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      poly_q  <= poly_d;
      step_q  <= step_d;
    end
  end

  // two-entry result queue storage
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_in;
    end
  end

  // result queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= !res_rd_q;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  assign empty          = (res_cnt_q == 2'd0);
  assign address_char_o = res_mem_q[res_rd_q].ch;
  assign last_char_o    = res_mem_q[res_rd_q].last;

endmodule

>>> rtl/core/bech32m_address_encoder.sv
// Bech32m witness version 1 address encoder. Push the 32 key bytes, first
// byte first; the result queue yields the ASCII characters "bc1p", 52 data
// characters and 6 checksum characters, with last_char_o set on the final
// one, after which the next byte starts a new address. The front end issues
// one command per cycle while the four-entry command queue has room (4 prefix
// commands on the first byte, 1 or 2 data symbols per byte, plus a padding
// symbol and a checksum command on the last byte), and takes a new byte once
// the commands of the previous one are issued. The back end writes one
// character per cycle into a two-entry result queue while that queue has room,
// and works through the checksum command and its six zero folds before its 6
// checksum characters; the sustained pace is set by the back end, with the
// output port taking one character per cycle.
`timescale 1ns / 1ps

module bech32m_address_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  key_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  address_char_o,
  output logic        last_char_o
);

  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_pop;
  logic            cmd_empty;
  b32m_pkg::cmd_t  cmd_wr;
  b32m_pkg::cmd_t  cmd_rd;

  // byte intake and bit regrouping
  b32m_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .key_byte_i (key_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr),
    .cmd_full_i (cmd_full)
  );

  // decoupling queue
  b32m_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_rd),
    .empty_o (cmd_empty)
  );

  // checksum and character output
  b32m_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_rd),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .pop            (pop),
    .empty          (empty),
    .address_char_o (address_char_o),
    .last_char_o    (last_char_o)
  );

`ifndef SYNTHESIS
  // front end never writes a full command queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("command transfer into a full queue");

  // back end never reads an empty command queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("command transfer from an empty queue");

  // any waiting result is a printable address character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (address_char_o >= 7'd48) && (address_char_o <= 7'd122))
    else $error("result character out of the address alphabet");
`endif

endmodule

>>> dv/testbench.sv
// testbench: bech32m address encoder checked against a cycle-free predictor
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] key_byte_i = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [6:0] address_char_o;
  logic       last_char_o;

  // idle rates in percent, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned char_count = 0;

  // predictor state
  logic [11:0]     pend_bits;
  int unsigned     pend_count;
  logic [29:0]     chk_state;
  int unsigned     key_pos;
  b32m_pkg::res_t  expected_chars[$];

  bech32m_address_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .key_byte_i     (key_byte_i),
    .empty          (empty),
    .pop            (pop),
    .address_char_o (address_char_o),
    .last_char_o    (last_char_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one bch polymod step over a 5-bit symbol
  function automatic logic [29:0] checksum_step(input logic [29:0] c, input logic [4:0] v);
    logic [29:0] r;
    r = {c[24:0], v};
    for (int i = 0; i < 5; i++) begin
      if (c[25 + i]) begin
        r = r ^ b32m_pkg::POLY_GEN[i];
      end
    end
    return r;
  endfunction

  // state at the start of an address: hrp expansion and version folded in
  function automatic void start_address();
    logic [4:0] hrp_vals [6];
    hrp_vals = '{5'd3, 5'd3, 5'd0, 5'd2, 5'd3, 5'd1};
    chk_state = 30'd1;
    foreach (hrp_vals[i]) begin
      chk_state = checksum_step(chk_state, hrp_vals[i]);
    end
    pend_bits  = '0;
    pend_count = 0;
    key_pos    = 0;
  endfunction

  // append one expected char at the tail of the queue
  function automatic void expect_char(input logic [6:0] ch, input logic is_last);
    b32m_pkg::res_t item;
    item.ch   = ch;
    item.last = is_last;
    expected_chars.insert(expected_chars.size(), item);
  endfunction

  function automatic void emit_symbol(input logic [4:0] v);
    chk_state = checksum_step(chk_state, v);
    expect_char(b32m_pkg::CHARSET[v], 1'b0);
  endfunction

  // expected characters caused by one accepted key byte
  function automatic void encode_key_byte(input logic [7:0] b);
    logic [29:0] c;
    if (key_pos == 0) begin
      for (int i = 0; i < $size(b32m_pkg::PREFIX_CHARS); i++) begin
        expect_char(b32m_pkg::PREFIX_CHARS[i], 1'b0);
      end
    end
    pend_bits  = {pend_bits[3:0], b};
    pend_count = pend_count + 8;
    while (pend_count >= 5) begin
      pend_count = pend_count - 5;
      emit_symbol(5'(pend_bits >> pend_count));
    end
    pend_bits = pend_bits & ((12'd1 << pend_count) - 12'd1);
    key_pos   = key_pos + 1;
    // last byte: padded leftover symbol, then the checksum
    if (key_pos >= b32m_pkg::KEY_BYTES) begin
      if (pend_count > 0) begin
        emit_symbol(5'(pend_bits << (5 - pend_count)));
      end
      c = chk_state;
      repeat (6) c = checksum_step(c, 5'd0);
      c = c ^ b32m_pkg::BECH32M_CONST;
      for (int i = 0; i < 6; i++) begin
        expect_char(b32m_pkg::CHARSET[5'(c >> (5 * (5 - i)))], (i == 5));
      end
      start_address();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at char %0d: %s", char_count, what);
    mismatch_count++;
  endtask

  // one key byte transfer, push stays high for a back-to-back follower
  task automatic send_key_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    key_byte_i <= b;
    do @(posedge clk_i); while (full);
    encode_key_byte(b);
  endtask

  task automatic wait_for_drain();
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // result checking, pop pacing and stall watchdog
  always @(posedge clk_i) begin
    b32m_pkg::res_t exp_res;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %02h", address_char_o));
        end else begin
          exp_res = expected_chars.pop_front();
          if (address_char_o !== exp_res.ch) begin
            report_mismatch($sformatf("address_char %02h, expected %02h",
                                      address_char_o, exp_res.ch));
          end
          if (last_char_o !== exp_res.last) begin
            report_mismatch($sformatf("last_char %b, expected %b",
                                      last_char_o, exp_res.last));
          end
        end
        char_count++;
      end
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("bech32m_address_encoder regression: fail");
        $finish;
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // one address with field extremes and walking patterns
  task automatic test_directed_key();
    logic [7:0] pattern [16];
    pattern = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h55, 8'haa, 8'h7f, 8'hfe,
                8'h0f, 8'hf0, 8'h33, 8'hcc, 8'h10, 8'h08, 8'h04, 8'h02};
    repeat (8) send_key_byte(8'h00);
    repeat (8) send_key_byte(8'hff);
    foreach (pattern[i]) send_key_byte(pattern[i]);
  endtask

  // whole random keys, a few of them constant to push checksum corners
  task automatic test_random_keys(input int n_keys);
    int unsigned style;
    repeat (n_keys) begin
      style = $urandom_range(5);
      for (int i = 0; i < b32m_pkg::KEY_BYTES; i++) begin
        case (style)
          0: send_key_byte(8'h00);
          1: send_key_byte(8'hff);
          default: send_key_byte(8'($urandom));
        endcase
      end
    end
  endtask

  // sender stops mid key until every pending char is out
  task automatic test_drain_mid_key();
    for (int i = 0; i < b32m_pkg::KEY_BYTES / 2; i++) send_key_byte(8'($urandom));
    push <= 1'b0;
    wait_for_drain();
    @(posedge clk_i);
    for (int i = b32m_pkg::KEY_BYTES / 2; i < b32m_pkg::KEY_BYTES; i++) begin
      send_key_byte(8'($urandom));
    end
  endtask

  initial begin
    start_address();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 45;
    test_directed_key();
    test_random_keys(3);
    test_drain_mid_key();

    send_idle_pct = 45;
    recv_idle_pct = 29;
    test_random_keys(3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_keys(3);
    push <= 1'b0;

    // drain, then watch for stray chars
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("bech32m_address_encoder regression: pass");
    end else begin
      $display("bech32m_address_encoder regression: fail");
    end
    $finish;
  end

endmodule

>>> bech32m_address_encoder.f
rtl/core/b32m_pkg.sv
rtl/core/b32m_front.sv
rtl/core/b32m_cmd_q.sv
rtl/core/b32m_back.sv
rtl/core/bech32m_address_encoder.sv
dv/testbench.sv
